// File: rtl/core/mncg_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the note-to-code table for the MIDI note to CV/gate block.
// No dependencies.

package mncg_pkg;

  localparam int MIDI_W = 8;
  localparam int CHAN_W = 4;
  localparam int NOTE_W = 7;
  localparam int CODE_W = 12;

  // Upper nibble of a status byte
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

  localparam logic [NOTE_W-1:0] NOTE_LOW  = 7'd21;
  localparam logic [NOTE_W-1:0] NOTE_HIGH = 7'd93;
  localparam int NOTE_SPAN = 93 - 21;
  localparam int CODE_FULL = 4095;

  // Position in the three-byte message
  localparam logic [1:0] POS_STATUS = 2'd0;
  localparam logic [1:0] POS_NOTE   = 2'd1;
  localparam logic [1:0] POS_VEL    = 2'd2;

  typedef logic [CODE_W-1:0] cv_table_t [NOTE_SPAN+1];

  // (note - low) * full / span, worked out at elaboration
  function automatic cv_table_t build_cv_table();
    cv_table_t t;
    for (int i = 0; i <= NOTE_SPAN; i++) begin
      t[i] = CODE_W'((i * CODE_FULL) / NOTE_SPAN);
    end
    return t;
  endfunction

  localparam cv_table_t CV_TABLE = build_cv_table();

endpackage

// File: rtl/core/midi_note_to_cv_gate.sv
`timescale 1ns / 1ps
// MIDI note to CV/gate converter: rebuilds note messages from a byte stream.
// Depends on mncg_pkg.
//
//  channel   dir  width  transaction
//  s_*       in   8      one received MIDI byte
//  m_*       out  32     gate, DAC update flag, code and frame bytes, one per byte
//  cfg_*     in   4      listened MIDI channel
//
// One byte per cycle: decode and table lookup sit between the message state
// and a single result register; a byte is taken while the result register is
// empty or being drained. Synchronous reset clears the message state, gate,
// code and channel. A stalled result holds the input off.

module midi_note_to_cv_gate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] midi_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] gate, [1] dac_update, [13:2] dac_code,
                                 // [21:14] dac_high_byte, [29:22] dac_low_byte, [31:30] 0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data   // [3:0] listen_channel
);

  logic [mncg_pkg::MIDI_W-1:0] status_byte, status_byte_next;
  logic [mncg_pkg::NOTE_W-1:0] note_byte, note_byte_next;
  logic [1:0]                  byte_pos, byte_pos_next;
  logic                        gate_level, gate_level_next;
  logic [mncg_pkg::CODE_W-1:0] cv_code, cv_code_next;
  logic                        dac_update, dac_update_next;
  logic [mncg_pkg::CHAN_W-1:0] listen_channel;

  logic                        accept;
  logic [mncg_pkg::MIDI_W-1:0] b;
  logic                        note_in_range;
  logic                        chan_match;
  logic [mncg_pkg::NOTE_W-1:0] note_ofs;
  logic [mncg_pkg::CODE_W-1:0] table_code;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign b         = s_tdata;

  assign note_in_range = (note_byte >= mncg_pkg::NOTE_LOW) && (note_byte <= mncg_pkg::NOTE_HIGH);
  assign chan_match    = (status_byte[3:0] == listen_channel);
  assign note_ofs      = note_byte - mncg_pkg::NOTE_LOW;
  // out-of-range offsets never reach the code register
  assign table_code    = (note_ofs <= mncg_pkg::NOTE_W'(mncg_pkg::NOTE_SPAN))
                         ? mncg_pkg::CV_TABLE[note_ofs] : '0;

  always_comb begin
    status_byte_next = status_byte;
    note_byte_next   = note_byte;
    byte_pos_next    = byte_pos;
    gate_level_next  = gate_level;
    cv_code_next     = cv_code;
    dac_update_next  = 1'b0;
    if (b[7]) begin
      status_byte_next = b;
      byte_pos_next    = mncg_pkg::POS_NOTE;
    end else begin
      unique case (byte_pos)
        mncg_pkg::POS_STATUS: begin
          status_byte_next = b;
          byte_pos_next    = mncg_pkg::POS_NOTE;
        end
        mncg_pkg::POS_NOTE: begin
          note_byte_next = b[6:0];
          byte_pos_next  = mncg_pkg::POS_VEL;
        end
        mncg_pkg::POS_VEL: begin
          // velocity byte completes the message
          byte_pos_next = mncg_pkg::POS_STATUS;
          if (note_in_range && chan_match) begin
            if (status_byte[7:4] == mncg_pkg::KIND_NOTE_ON) begin
              if (b != '0) begin
                cv_code_next    = table_code;
                gate_level_next = 1'b1;
                dac_update_next = 1'b1;
              end else begin
                gate_level_next = 1'b0;
              end
            end else if (status_byte[7:4] == mncg_pkg::KIND_NOTE_OFF) begin
              gate_level_next = 1'b0;
            end
          end
        end
        default: begin
          // unreachable position: data byte dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_byte    <= '0;
      note_byte      <= '0;
      byte_pos       <= mncg_pkg::POS_STATUS;
      gate_level     <= 1'b0;
      cv_code        <= '0;
      dac_update     <= 1'b0;
      m_tvalid       <= 1'b0;
      listen_channel <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        listen_channel <= cfg_data;
      end
      if (accept) begin
        status_byte <= status_byte_next;
        note_byte   <= note_byte_next;
        byte_pos    <= byte_pos_next;
        gate_level  <= gate_level_next;
        cv_code     <= cv_code_next;
        dac_update  <= dac_update_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // state only moves on an accepted byte, so it doubles as the result register
  assign m_tdata = {2'b00, cv_code[3:0], 4'b0000, cv_code[11:4], cv_code,
                    dac_update, gate_level};

endmodule
